[sv/clrs_pkg.sv]
// Shared types and constants of the rotate-and-scale block
package clrs_pkg;

    localparam int POS_W        = 16;
    localparam int IDX_W        = 6;
    localparam int PHASE_W      = 16;
    localparam int RATIO_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int W_W          = 32;
    localparam int NUM_W        = 34;
    localparam int REM_W        = 16;
    localparam int DIV_STAGES   = NUM_W;
    localparam int CORDIC_STEPS = 16;
    localparam int PROD_W       = 64;
    localparam int SCL_W        = 50;

    localparam logic [RATIO_W-1:0] RATIO_FLOOR = 16'd41;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;
    localparam logic signed [PROD_W-1:0] INV_GAIN = 64'sd652032874;

    typedef logic signed [W_W-1:0] t_word;

    localparam t_word ATAN [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE = 2'd0,
        CFG_RATIO = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic             valid;
        logic             inv;
        logic [IDX_W-1:0] idx;
    } t_side;

endpackage

[sv/clrs_if.sv]
// Channel interfaces: request, result and configuration write
interface clrs_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [clrs_pkg::IDX_W-1:0]          source_index;
    logic signed [clrs_pkg::POS_W-1:0]   pos_x;
    logic signed [clrs_pkg::POS_W-1:0]   pos_y;
    modport source (output valid, req_type, source_index, pos_x, pos_y, input ready);
    modport sink (input valid, req_type, source_index, pos_x, pos_y, output ready);
endinterface

interface clrs_res_if;
    logic                                valid;
    logic                                ready;
    logic [clrs_pkg::IDX_W-1:0]          out_index;
    logic signed [clrs_pkg::POS_W-1:0]   out_x;
    logic signed [clrs_pkg::POS_W-1:0]   out_y;
    logic                                saturated;
    modport source (output valid, out_index, out_x, out_y, saturated, input ready);
    modport sink (input valid, out_index, out_x, out_y, saturated, output ready);
endinterface

interface clrs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [clrs_pkg::CFG_IDX_W-1:0]      index;
    logic [clrs_pkg::RATIO_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/clrs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, both coordinates
module clrs_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  clrs_pkg::t_side                    i_side,
    input  logic signed [clrs_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [clrs_pkg::POS_W-1:0]  i_pos_y,
    input  logic [clrs_pkg::RATIO_W-1:0]       i_ratio,
    output clrs_pkg::t_side                    o_side,
    output clrs_pkg::t_word                    o_w_x,
    output clrs_pkg::t_word                    o_w_y
);
    import clrs_pkg::*;

    logic [REM_W-1:0]        r_rem [DIV_STAGES][2];
    logic [NUM_W-1:0]        r_nq  [DIV_STAGES][2];
    logic signed [POS_W-1:0] r_pos [DIV_STAGES][2];
    t_side                   r_side [DIV_STAGES];

    logic [REM_W-1:0]        n_rem [DIV_STAGES][2];
    logic [NUM_W-1:0]        n_nq  [DIV_STAGES][2];
    logic [REM_W-1:0]        s_rem [DIV_STAGES][2];
    logic [NUM_W-1:0]        s_nq  [DIV_STAGES][2];
    logic signed [POS_W-1:0] in_pos [2];
    logic [REM_W:0]          sh;
    logic                    ge;
    logic [POS_W:0]          mag;

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag = in_pos[l][POS_W-1] ? (POS_W+1)'(-$signed({in_pos[l][POS_W-1], in_pos[l]}))
                                     : (POS_W+1)'({1'b0, in_pos[l]});
            s_rem[0][l] = '0;
            s_nq[0][l]  = NUM_W'({mag, 18'b0}) + NUM_W'(i_ratio[RATIO_W-1:1]);
            for (int s = 1; s < DIV_STAGES; s++) begin
                s_rem[s][l] = r_rem[s-1][l];
                s_nq[s][l]  = r_nq[s-1][l];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                sh = {s_rem[s][l], s_nq[s][l][NUM_W-1]};
                ge = (sh >= {1'b0, i_ratio});
                n_rem[s][l] = ge ? REM_W'(sh - {1'b0, i_ratio}) : sh[REM_W-1:0];
                n_nq[s][l]  = {s_nq[s][l][NUM_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) r_side[s] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < DIV_STAGES; s++) r_side[s] <= r_side[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_pos[0][l] <= in_pos[l];
                for (int s = 1; s < DIV_STAGES; s++) r_pos[s][l] <= r_pos[s-1][l];
                for (int s = 0; s < DIV_STAGES; s++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_nq[s][l]  <= n_nq[s][l];
                end
            end
        end
    end

    function automatic t_word pick(input logic inv, input logic signed [POS_W-1:0] pos,
                                   input logic [NUM_W-1:0] q);
        t_word qw;
        qw = W_W'(q);
        if (!inv) return t_word'(pos) <<< 6;
        return pos[POS_W-1] ? -qw : qw;
    endfunction

    assign o_side = r_side[DIV_STAGES-1];
    assign o_w_x  = pick(r_side[DIV_STAGES-1].inv, r_pos[DIV_STAGES-1][0],
                         r_nq[DIV_STAGES-1][0]);
    assign o_w_y  = pick(r_side[DIV_STAGES-1].inv, r_pos[DIV_STAGES-1][1],
                         r_nq[DIV_STAGES-1][1]);

endmodule

[sv/clrs_cordic.sv]
// Quadrant fold and sixteen-stage CORDIC rotator
module clrs_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  clrs_pkg::t_side               i_side,
    input  clrs_pkg::t_word               i_w_x,
    input  clrs_pkg::t_word               i_w_y,
    input  logic [clrs_pkg::PHASE_W-1:0]  i_phase,
    output clrs_pkg::t_side               o_side,
    output clrs_pkg::t_word               o_x,
    output clrs_pkg::t_word               o_y
);
    import clrs_pkg::*;

    localparam int NST = CORDIC_STEPS + 1;

    t_side r_side [NST];
    t_word r_x [NST];
    t_word r_y [NST];
    t_word r_z [NST];
    t_word n_x [NST];
    t_word n_y [NST];
    t_word n_z [NST];

    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] qt;
    logic               fold;
    t_word              dx;
    t_word              dy;

    always_comb begin
        ph   = i_side.inv ? PHASE_W'(-i_phase) : i_phase;
        qt   = ph + 16'd16384;
        fold = qt[PHASE_W-1];
        n_x[0] = fold ? -i_w_x : i_w_x;
        n_y[0] = fold ? -i_w_y : i_w_y;
        n_z[0] = t_word'({fold ? ph + 16'd32768 : ph, 16'b0});
        for (int k = 1; k < NST; k++) begin
            dx = r_y[k-1] >>> (k-1);
            dy = r_x[k-1] >>> (k-1);
            if (!r_z[k-1][W_W-1]) begin
                n_x[k] = r_x[k-1] - dx;
                n_y[k] = r_y[k-1] + dy;
                n_z[k] = r_z[k-1] - ATAN[k-1];
            end else begin
                n_x[k] = r_x[k-1] + dx;
                n_y[k] = r_y[k-1] - dy;
                n_z[k] = r_z[k-1] + ATAN[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_side[k] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NST; k++) r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NST; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    assign o_side = r_side[NST-1];
    assign o_x    = r_x[NST-1];
    assign o_y    = r_y[NST-1];

endmodule

[sv/clrs_post.sv]
// Gain correction, radius scaling of non-inverse requests, rounding and clipping, ending in the output register
module clrs_post (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  clrs_pkg::t_side                    i_side,
    input  clrs_pkg::t_word                    i_x,
    input  clrs_pkg::t_word                    i_y,
    input  logic [clrs_pkg::RATIO_W-1:0]       i_ratio,
    output clrs_pkg::t_side                    o_side,
    output logic signed [clrs_pkg::POS_W-1:0]  o_x,
    output logic signed [clrs_pkg::POS_W-1:0]  o_y,
    output logic                               o_sat
);
    import clrs_pkg::*;

    t_side r_side [3];
    t_word r_g [2];
    t_word r_v [2];
    logic signed [POS_W-1:0] r_o [2];
    logic r_sat;

    t_word                    n_g [2];
    t_word                    n_v [2];
    logic signed [POS_W-1:0]  n_o [2];
    logic                     n_clip [2];
    t_word                    in_v [2];
    logic signed [PROD_W-1:0] prod;
    logic signed [SCL_W-1:0]  scl;

    assign in_v[0] = i_x;
    assign in_v[1] = i_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            prod   = PROD_W'(in_v[l]) * INV_GAIN + (64'sd1 <<< 29);
            n_g[l] = W_W'(prod >>> 30);
            scl    = SCL_W'(r_g[l]) * $signed({1'b0, i_ratio}) + (50'sd1 <<< 17);
            n_v[l] = r_side[0].inv ? (r_g[l] + 32'sd32) >>> 6 : W_W'(scl >>> 18);
            if (r_v[l] > 32'sd32767) begin
                n_o[l] = 16'sh7FFF; n_clip[l] = 1'b1;
            end else if (r_v[l] < -32'sd32768) begin
                n_o[l] = -16'sh8000; n_clip[l] = 1'b1;
            end else begin
                n_o[l] = r_v[l][POS_W-1:0]; n_clip[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_side[k] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_g[l] <= n_g[l];
                r_v[l] <= n_v[l];
                r_o[l] <= n_o[l];
            end
            r_sat <= n_clip[0] | n_clip[1];
        end
    end

    assign o_side = r_side[2];
    assign o_x    = r_o[0];
    assign o_y    = r_o[1];
    assign o_sat  = r_sat;

endmodule

[sv/circular_link_rotate_scale.sv]
// Pipeline: 34 divider, 17 CORDIC and 3 post stages lie between accepted word and result.
// Throughput: one word per cycle; the whole pipeline holds while the result is not taken.
// Depth is set mostly by the bit-per-stage divider and the stage-per-step CORDIC rotator.
// Reset: synchronous, active low; clears valid bits, phase to 0 and ratio to 1.0.
module circular_link_rotate_scale (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clrs_req_if.sink  i_req,
    clrs_res_if.source o_res,
    clrs_cfg_if.sink  i_cfg
);
    import clrs_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [RATIO_W-1:0] r_ratio;
    logic               en;
    t_side              in_side;
    t_side              div_side;
    t_side              cor_side;
    t_side              out_side;
    t_word              w_x, w_y, c_x, c_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_ratio <= RATIO_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_PHASE: r_phase <= i_cfg.data;
                CFG_RATIO: r_ratio <= (i_cfg.data < RATIO_FLOOR) ? RATIO_FLOOR : i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign en          = !out_side.valid || o_res.ready;
    assign i_req.ready = en;
    assign in_side     = '{valid: i_req.valid, inv: i_req.req_type, idx: i_req.source_index};

    clrs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(in_side),
        .i_pos_x(i_req.pos_x), .i_pos_y(i_req.pos_y), .i_ratio(r_ratio),
        .o_side(div_side), .o_w_x(w_x), .o_w_y(w_y)
    );

    clrs_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(div_side),
        .i_w_x(w_x), .i_w_y(w_y), .i_phase(r_phase),
        .o_side(cor_side), .o_x(c_x), .o_y(c_y)
    );

    clrs_post u_post (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(cor_side),
        .i_x(c_x), .i_y(c_y), .i_ratio(r_ratio),
        .o_side(out_side), .o_x(o_res.out_x), .o_y(o_res.out_y),
        .o_sat(o_res.saturated)
    );

    assign o_res.valid     = out_side.valid;
    assign o_res.out_index = out_side.idx;

    a_ratio_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ratio >= RATIO_FLOOR) else $error("ratio below floor");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.saturated) |->
        (o_res.out_x == 16'sh7FFF || o_res.out_x == -16'sh8000 ||
         o_res.out_y == 16'sh7FFF || o_res.out_y == -16'sh8000))
        else $error("saturation flag without clipped coordinate");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid) else $error("result valid after reset");

endmodule
